/* rtl/core/mct_pkg.sv */
// shared types and constants for the mouse cursor tracker
package mct_pkg;

	localparam int COORD_BITS    = 12;
	localparam int RATIO_BITS    = 8;
	localparam int MICKEY_BITS   = 16;
	localparam int NUM_BUTTONS   = 3;
	localparam int EVT_BITS      = 7;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;
	localparam int DIV_STEPS     = MICKEY_BITS;
	localparam int CNT_BITS      = $clog2(DIV_STEPS);

	localparam logic [COORD_BITS-1:0] WIDTH_RST  = 12'd639;
	localparam logic [COORD_BITS-1:0] HEIGHT_RST = 12'd479;
	localparam logic [RATIO_BITS-1:0] RATIO_ONE  = 8'd1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ENABLE,
		CFG_X_RATIO,
		CFG_Y_RATIO,
		CFG_SCREEN_WIDTH,
		CFG_SCREEN_HEIGHT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_RUN,
		TOP_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		LANE_IDLE,
		LANE_DIV,
		LANE_FIN
	} lane_state_t;

	typedef struct packed {
		logic [EVT_BITS-1:0]           event_bits;
		logic signed [MICKEY_BITS-1:0] count_x;
		logic signed [MICKEY_BITS-1:0] count_y;
		logic [NUM_BUTTONS-1:0]        latch_clear;
	} evt_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]  cursor_x;
		logic [COORD_BITS-1:0]  cursor_y;
		logic [NUM_BUTTONS-1:0] buttons_down;
		logic [NUM_BUTTONS-1:0] press_latched;
		logic [COORD_BITS-1:0]  left_press_x;
		logic [COORD_BITS-1:0]  left_press_y;
		logic [COORD_BITS-1:0]  right_press_x;
		logic [COORD_BITS-1:0]  right_press_y;
		logic [COORD_BITS-1:0]  middle_press_x;
		logic [COORD_BITS-1:0]  middle_press_y;
	} cur_item_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0]                 levels;
		logic [NUM_BUTTONS-1:0]                 latches;
		logic [NUM_BUTTONS-1:0][COORD_BITS-1:0] press_x;
		logic [NUM_BUTTONS-1:0][COORD_BITS-1:0] press_y;
	} btn_state_t;

endpackage

/* rtl/core/mct_axis_lane.sv */
// one axis lane: wrapped delta, serial floor divide by the ratio, clamp
module mct_axis_lane import mct_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [MICKEY_BITS-1:0] mickey,
	input  logic [RATIO_BITS-1:0]         ratio,
	input  logic [COORD_BITS-1:0]         limit,
	output logic                          busy,
	output logic [COORD_BITS-1:0]         pos
);

	lane_state_t state_q, state_d;

	logic [MICKEY_BITS-1:0] last_q;
	logic [COORD_BITS-1:0]  pos_q;
	logic [RATIO_BITS-1:0]  rem_q;
	logic [MICKEY_BITS-1:0] dvd_q;
	logic [RATIO_BITS-1:0]  part_q;
	logic [RATIO_BITS-1:0]  div_q;
	logic                   neg_q;
	logic                   zero_q;
	logic [CNT_BITS-1:0]    cnt_q;

	logic do_load, do_step, do_fin;

	logic [MICKEY_BITS-1:0] diff;
	logic                   delta_zero;
	logic [MICKEY_BITS:0]   sum;
	logic [MICKEY_BITS-1:0] mag;
	logic [RATIO_BITS-1:0]  ratio_eff;

	logic [RATIO_BITS:0]    trial;
	logic [RATIO_BITS:0]    trial_sub;
	logic                   ge;

	logic [MICKEY_BITS:0]   quo;
	logic [RATIO_BITS-1:0]  mod_val;
	logic [MICKEY_BITS+1:0] newp;
	logic [COORD_BITS-1:0]  clamped;

	// set-up: remainder plus delta, folded to a nonnegative dividend
	always_comb begin
		diff       = MICKEY_BITS'(mickey) - last_q;
		delta_zero = (diff == '0);
		sum        = {{(MICKEY_BITS+1-RATIO_BITS){1'b0}}, rem_q} + {diff[MICKEY_BITS-1], diff};
		// negative sum divides -s-1 and is corrected at the end
		mag        = sum[MICKEY_BITS] ? ~sum[MICKEY_BITS-1:0] : sum[MICKEY_BITS-1:0];
		ratio_eff  = (ratio == '0) ? RATIO_ONE : ratio;
	end

	// one restoring step per cycle
	always_comb begin
		trial     = {part_q, dvd_q[MICKEY_BITS-1]};
		ge        = (trial >= {1'b0, div_q});
		trial_sub = trial - {1'b0, div_q};
	end

	always_comb begin
		if (zero_q) begin
			quo     = '0;
			mod_val = rem_q;
		end else if (neg_q) begin
			quo     = {1'b1, ~dvd_q};
			mod_val = div_q - RATIO_ONE - part_q;
		end else begin
			quo     = {1'b0, dvd_q};
			mod_val = part_q;
		end
		newp = {{(MICKEY_BITS+2-COORD_BITS){1'b0}}, pos_q} + {quo[MICKEY_BITS], quo};
		if (newp[MICKEY_BITS+1]) begin
			clamped = '0;
		end else if (newp[MICKEY_BITS:0] > {{(MICKEY_BITS+1-COORD_BITS){1'b0}}, limit}) begin
			clamped = limit;
		end else begin
			clamped = newp[COORD_BITS-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LANE_IDLE: begin
				if (start) begin
					state_d = delta_zero ? LANE_FIN : LANE_DIV;
				end
			end
			LANE_DIV: begin
				if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
					state_d = LANE_FIN;
				end
			end
			LANE_FIN:  state_d = LANE_IDLE;
			default:   state_d = LANE_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q != LANE_IDLE);
		do_load = (state_q == LANE_IDLE) && start;
		do_step = (state_q == LANE_DIV);
		do_fin  = (state_q == LANE_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LANE_IDLE;
			last_q  <= '0;
			pos_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (do_load) begin
				last_q <= MICKEY_BITS'(mickey);
			end
			if (do_fin) begin
				pos_q <= clamped;
				rem_q <= mod_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			dvd_q  <= mag;
			part_q <= '0;
			div_q  <= ratio_eff;
			neg_q  <= sum[MICKEY_BITS];
			zero_q <= delta_zero;
			cnt_q  <= '0;
		end else if (do_step) begin
			dvd_q  <= {dvd_q[MICKEY_BITS-2:0], ge};
			part_q <= ge ? trial_sub[RATIO_BITS-1:0] : trial[RATIO_BITS-1:0];
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign pos = pos_q;

endmodule

/* rtl/core/mct_buttons.sv */
// button levels, press latches and captured press positions
module mct_buttons import mct_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   enable,
	input  logic [EVT_BITS-1:0]    event_bits,
	input  logic [NUM_BUTTONS-1:0] latch_clear,
	input  logic [COORD_BITS-1:0]  pos_x,
	input  logic [COORD_BITS-1:0]  pos_y,
	output btn_state_t             btn
);

	btn_state_t btn_q, btn_d;

	always_comb begin
		btn_d = btn_q;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			// latch clear applies even when tracking is off
			btn_d.latches[b] = btn_q.latches[b] & ~latch_clear[b];
			if (enable) begin
				if (event_bits[2*b+1]) begin
					btn_d.levels[b] = 1'b1;
					if (!btn_d.latches[b]) begin
						btn_d.latches[b] = 1'b1;
						btn_d.press_x[b] = pos_x;
						btn_d.press_y[b] = pos_y;
					end
				end
				// release after press, so both together leave the level clear
				if (event_bits[2*b+2]) begin
					btn_d.levels[b] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q <= '0;
		end else if (load) begin
			btn_q <= btn_d;
		end
	end

	assign btn = btn_q;

endmodule

/* rtl/core/mouse_cursor_tracker.sv */
// mouse cursor tracker top level: config, lane control and result register
//
//   channel  direction  handshake             payload
//   evt      in         evt_valid/evt_stall   evt_data (evt_item_t)
//   cur      out        cur_valid/cur_stall   cur_data (cur_item_t)
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// one event at a time; an enabled event with movement on either axis has its result
// registered once the 16-step serial dividers of the x and y lanes, running side by side,
// finish; with no movement the lanes skip the divide, and a disabled event skips the lanes
// the next event is taken from the cycle after its result is registered
// reset: tracking off, ratios 1, screen 639 by 479, cursor and latches cleared
// a new event is taken while the previous result waits in the output register;
// a finished result waits for that register to empty
module mouse_cursor_tracker import mct_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     evt_valid,
	output logic                     evt_stall,
	input  evt_item_t                evt_data,
	output logic                     cur_valid,
	input  logic                     cur_stall,
	output cur_item_t                cur_data
);

	logic                  enable_q;
	logic [RATIO_BITS-1:0] x_ratio_q, y_ratio_q;
	logic [COORD_BITS-1:0] width_q, height_q;

	top_state_t state_q, state_d;

	logic      evt_acc;
	logic      lane_start;
	logic      commit;
	logic      x_busy, y_busy;
	logic [COORD_BITS-1:0] x_pos, y_pos;
	btn_state_t btn;

	logic      out_valid_q;
	cur_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			x_ratio_q <= RATIO_ONE;
			y_ratio_q <= RATIO_ONE;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ENABLE:        enable_q  <= cfg_data[0];
				CFG_X_RATIO:       x_ratio_q <= cfg_data[RATIO_BITS-1:0];
				CFG_Y_RATIO:       y_ratio_q <= cfg_data[RATIO_BITS-1:0];
				CFG_SCREEN_WIDTH:  width_q   <= cfg_data[COORD_BITS-1:0];
				CFG_SCREEN_HEIGHT: height_q  <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (evt_acc) begin
					state_d = enable_q ? TOP_RUN : TOP_DONE;
				end
			end
			TOP_RUN: begin
				if (!x_busy && !y_busy) begin
					state_d = TOP_DONE;
				end
			end
			TOP_DONE: begin
				if (commit) begin
					state_d = TOP_IDLE;
				end
			end
			default: state_d = TOP_IDLE;
		endcase
	end

	always_comb begin
		evt_stall  = (state_q != TOP_IDLE);
		evt_acc    = evt_valid && (state_q == TOP_IDLE);
		lane_start = evt_acc && enable_q;
		commit     = (state_q == TOP_DONE) && (!out_valid_q || !cur_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!cur_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	mct_axis_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.mickey (evt_data.count_x),
		.ratio  (x_ratio_q),
		.limit  (width_q),
		.busy   (x_busy),
		.pos    (x_pos)
	);

	mct_axis_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.mickey (evt_data.count_y),
		.ratio  (y_ratio_q),
		.limit  (height_q),
		.busy   (y_busy),
		.pos    (y_pos)
	);

	// buttons see the cursor from before this event's move
	mct_buttons u_buttons (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (evt_acc),
		.enable      (enable_q),
		.event_bits  (evt_data.event_bits),
		.latch_clear (evt_data.latch_clear),
		.pos_x       (x_pos),
		.pos_y       (y_pos),
		.btn         (btn)
	);

	// merge lane positions and button state into one result
	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.cursor_x       <= x_pos;
			out_q.cursor_y       <= y_pos;
			out_q.buttons_down   <= btn.levels;
			out_q.press_latched  <= btn.latches;
			out_q.left_press_x   <= btn.press_x[0];
			out_q.left_press_y   <= btn.press_y[0];
			out_q.right_press_x  <= btn.press_x[1];
			out_q.right_press_y  <= btn.press_y[1];
			out_q.middle_press_x <= btn.press_x[2];
			out_q.middle_press_y <= btn.press_y[2];
		end
	end

	assign cur_valid = out_valid_q;
	assign cur_data  = out_q;

`ifndef NO_ASSERTIONS
	a_lanes_start: assert property (@(posedge clk) disable iff (!arst_n)
		lane_start |=> (x_busy && y_busy))
		else $error("lanes did not start on an enabled event");

	a_lanes_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(x_busy || y_busy) |-> (state_q == TOP_RUN))
		else $error("lane busy outside the run state");

	a_disabled_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_acc && !enable_q) |=> $stable(btn.levels))
		else $error("button levels changed while tracking is off");
`endif

endmodule

/* verif/tb_mouse_cursor_tracker.sv */
// self-checking testbench for the mouse cursor tracker: directed and random events
module tb_mouse_cursor_tracker;
	import mct_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 40;
	localparam int PHASES         = 8;
	localparam int BLOCKS         = 5;
	localparam int BLOCK_ITEMS    = 50;

	// event bit codes
	localparam logic [EVT_BITS-1:0] EV_NONE        = 7'h00;
	localparam logic [EVT_BITS-1:0] EV_SPARE       = 7'h01;
	localparam logic [EVT_BITS-1:0] EV_LEFT_DOWN   = 7'h02;
	localparam logic [EVT_BITS-1:0] EV_LEFT_UP     = 7'h04;
	localparam logic [EVT_BITS-1:0] EV_RIGHT_DOWN  = 7'h08;
	localparam logic [EVT_BITS-1:0] EV_RIGHT_UP    = 7'h10;
	localparam logic [EVT_BITS-1:0] EV_MIDDLE_DOWN = 7'h20;
	localparam logic [EVT_BITS-1:0] EV_MIDDLE_UP   = 7'h40;
	localparam logic [EVT_BITS-1:0] EV_ALL_DOWN    = 7'h2A;
	localparam logic [EVT_BITS-1:0] EV_ALL         = 7'h7F;

	localparam logic [NUM_BUTTONS-1:0] CLR_NONE   = 3'b000;
	localparam logic [NUM_BUTTONS-1:0] CLR_LEFT   = 3'b001;
	localparam logic [NUM_BUTTONS-1:0] CLR_OUTER  = 3'b101;
	localparam logic [NUM_BUTTONS-1:0] CLR_ALL    = 3'b111;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     evt_valid = 1'b0;
	logic                     evt_stall;
	evt_item_t                evt_data = '0;
	logic                     cur_valid;
	logic                     cur_stall = 1'b0;
	cur_item_t                cur_data;

	// predictor copy of the registers and tracking state
	logic                    trk_enable;
	logic [RATIO_BITS-1:0]   trk_x_ratio, trk_y_ratio;
	logic [COORD_BITS-1:0]   trk_width, trk_height;
	logic [COORD_BITS-1:0]   trk_x, trk_y;
	logic [RATIO_BITS-1:0]   frac_x, frac_y;
	logic [MICKEY_BITS-1:0]  prev_mx, prev_my;
	logic [NUM_BUTTONS-1:0]  btn_levels, btn_latches;
	logic [COORD_BITS-1:0]   grab_x [NUM_BUTTONS];
	logic [COORD_BITS-1:0]   grab_y [NUM_BUTTONS];

	cur_item_t               expected_cursor_q [$];
	logic [MICKEY_BITS-1:0]  sent_mx = '0, sent_my = '0;
	logic                    idling = 1'b1;
	int                      events_sent, cursors_checked, reg_writes, mismatches;
	int                      idle_cycles, stall_left;

	mouse_cursor_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_data  (evt_data),
		.cur_valid (cur_valid),
		.cur_stall (cur_stall),
		.cur_data  (cur_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic clear_tracking();
		trk_enable  = 1'b0;
		trk_x_ratio = RATIO_ONE;
		trk_y_ratio = RATIO_ONE;
		trk_width   = WIDTH_RST;
		trk_height  = HEIGHT_RST;
		trk_x = '0; trk_y = '0; frac_x = '0; frac_y = '0;
		prev_mx = '0; prev_my = '0; btn_levels = '0; btn_latches = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			grab_x[b] = '0;
			grab_y[b] = '0;
		end
	endtask

	// one axis: returns {position, remainder}
	function automatic logic [COORD_BITS+RATIO_BITS-1:0] axis_step(
		logic [COORD_BITS-1:0] pos, logic [RATIO_BITS-1:0] rem,
		logic [MICKEY_BITS-1:0] last, logic [MICKEY_BITS-1:0] now,
		logic [RATIO_BITS-1:0] ratio, logic [COORD_BITS-1:0] limit);
		logic [MICKEY_BITS-1:0] diff;
		logic [RATIO_BITS-1:0]  new_rem;
		int delta, r, p, s, q, m;
		diff    = now - last;
		delta   = diff[MICKEY_BITS-1] ? int'(diff) - 65536 : int'(diff);
		r       = (ratio == '0) ? 1 : int'(ratio);
		p       = int'(pos);
		new_rem = rem;
		if (delta != 0) begin
			s = int'(rem) + delta;
			q = s / r;
			m = s % r;
			// floor division: pull a negative modulus back into range
			if (m < 0) begin
				m += r;
				q -= 1;
			end
			new_rem = m[RATIO_BITS-1:0];
			p += q;
		end
		if (p < 0)
			p = 0;
		if (p > int'(limit))
			p = int'(limit);
		return {p[COORD_BITS-1:0], new_rem};
	endfunction

	function automatic cur_item_t predict_cursor(evt_item_t it);
		logic [COORD_BITS+RATIO_BITS-1:0] ax;
		cur_item_t r;
		btn_latches &= ~it.latch_clear;
		if (trk_enable) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				if (it.event_bits[1 + 2*b]) begin
					btn_levels[b] = 1'b1;
					if (!btn_latches[b]) begin
						btn_latches[b] = 1'b1;
						grab_x[b] = trk_x;
						grab_y[b] = trk_y;
					end
				end
				// release after press, so a press and release together ends up released
				if (it.event_bits[2 + 2*b])
					btn_levels[b] = 1'b0;
			end
			ax = axis_step(trk_x, frac_x, prev_mx, it.count_x, trk_x_ratio, trk_width);
			{trk_x, frac_x} = ax;
			prev_mx = it.count_x;
			ax = axis_step(trk_y, frac_y, prev_my, it.count_y, trk_y_ratio, trk_height);
			{trk_y, frac_y} = ax;
			prev_my = it.count_y;
		end
		r.cursor_x       = trk_x;
		r.cursor_y       = trk_y;
		r.buttons_down   = btn_levels;
		r.press_latched  = btn_latches;
		r.left_press_x   = grab_x[0];
		r.left_press_y   = grab_y[0];
		r.right_press_x  = grab_x[1];
		r.right_press_y  = grab_y[1];
		r.middle_press_x = grab_x[2];
		r.middle_press_y = grab_y[2];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("cursor %0d %s got %0d want %0d",
				cursors_checked, name, got, want));
	endtask

	// result checker
	always @(posedge clk) begin
		cur_item_t want;
		if (arst_n && cur_valid && !cur_stall) begin
			if (expected_cursor_q.size() == 0) begin
				report_mismatch("cursor transfer with nothing expected");
			end else begin
				want = expected_cursor_q.pop_front();
				check_field("cursor_x", cur_data.cursor_x, want.cursor_x);
				check_field("cursor_y", cur_data.cursor_y, want.cursor_y);
				check_field("buttons_down", cur_data.buttons_down, want.buttons_down);
				check_field("press_latched", cur_data.press_latched, want.press_latched);
				check_field("left_press_x", cur_data.left_press_x, want.left_press_x);
				check_field("left_press_y", cur_data.left_press_y, want.left_press_y);
				check_field("right_press_x", cur_data.right_press_x, want.right_press_x);
				check_field("right_press_y", cur_data.right_press_y, want.right_press_y);
				check_field("middle_press_x", cur_data.middle_press_x, want.middle_press_x);
				check_field("middle_press_y", cur_data.middle_press_y, want.middle_press_y);
			end
			cursors_checked++;
		end
	end

	// output back-pressure in bursts of random length while idling is set
	always @(posedge clk) begin
		if (!arst_n || !idling) begin
			cur_stall  <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			cur_stall  <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			cur_stall  <= 1'b1;
			stall_left = $urandom_range(0, 11);
		end else begin
			cur_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (evt_valid && !evt_stall) || (cur_valid && !cur_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_event(evt_item_t it);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt_data  <= it;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		expected_cursor_q.push_back(predict_cursor(it));
		sent_mx = it.count_x;
		sent_my = it.count_y;
		events_sent++;
	endtask

	// let the block run dry before touching its registers
	task automatic settle();
		evt_valid <= 1'b0;
		while (expected_cursor_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ENABLE:        trk_enable  = val[0];
			CFG_X_RATIO:       trk_x_ratio = val[RATIO_BITS-1:0];
			CFG_Y_RATIO:       trk_y_ratio = val[RATIO_BITS-1:0];
			CFG_SCREEN_WIDTH:  trk_width   = val;
			CFG_SCREEN_HEIGHT: trk_height  = val;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	function automatic evt_item_t mk(logic [EVT_BITS-1:0] ev, int mx, int my,
		logic [NUM_BUTTONS-1:0] clr);
		evt_item_t it;
		it.event_bits  = ev;
		it.count_x     = 16'(mx);
		it.count_y     = 16'(my);
		it.latch_clear = clr;
		return it;
	endfunction

	function automatic logic [MICKEY_BITS-1:0] mickey_step();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2, 3, 4, 5, 6: return 16'(int'($urandom_range(0, 80)) - 40);
			7, 8:    return 16'(int'($urandom_range(0, 4000)) - 2000);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic evt_item_t random_event();
		evt_item_t it;
		int b;
		b = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			0, 1, 2: it.event_bits = 7'(EV_LEFT_DOWN << (2*b));
			3, 4:    it.event_bits = 7'(EV_LEFT_UP << (2*b));
			5:       it.event_bits = 7'((EV_LEFT_DOWN | EV_LEFT_UP) << (2*b));
			6, 7:    it.event_bits = EV_NONE;
			default: it.event_bits = 7'($urandom_range(0, 127));
		endcase
		it.count_x     = sent_mx + mickey_step();
		it.count_y     = sent_my + mickey_step();
		it.latch_clear = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CLR_NONE;
		return it;
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_ratio();
		// upper data bits are junk the block must drop
		logic [CFG_DATA_BITS-1:0] junk;
		junk = 12'($urandom_range(0, 15)) << RATIO_BITS;
		case ($urandom_range(0, 5))
			0:       return junk | 12'd0;
			1:       return junk | 12'd1;
			2:       return junk | 12'd255;
			3:       return junk | 12'($urandom_range(2, 4));
			default: return junk | 12'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_limit();
		case ($urandom_range(0, 4))
			0:       return 12'd0;
			1:       return 12'd4095;
			2:       return 12'd639;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// events while tracking is off change nothing
	task automatic test_disabled_events();
		send_event(mk(EV_ALL & ~EV_SPARE, 100, -50, CLR_NONE));
		send_event(mk(EV_ALL_DOWN, 300, 300, CLR_ALL));
		settle();
		write_reg(CFG_ENABLE, 12'h001);
		write_reg(CFG_X_RATIO, 12'h001);
		write_reg(CFG_Y_RATIO, 12'h001);
		write_reg(CFG_SCREEN_WIDTH, 12'd639);
		write_reg(CFG_SCREEN_HEIGHT, 12'd479);
	endtask

	task automatic test_buttons();
		send_event(mk(EV_LEFT_DOWN, 50, 40, CLR_NONE));
		// latch already set: no new capture
		send_event(mk(EV_LEFT_DOWN, 60, 45, CLR_NONE));
		send_event(mk(EV_LEFT_UP, 60, 45, CLR_NONE));
		send_event(mk(EV_RIGHT_DOWN | EV_RIGHT_UP, 70, 50, CLR_NONE));
		send_event(mk(EV_MIDDLE_DOWN | EV_SPARE, 80, 60, CLR_NONE));
		// clear comes first, so the press captures again
		send_event(mk(EV_LEFT_DOWN, 90, 70, CLR_LEFT));
		send_event(mk(EV_ALL, 100, 80, CLR_ALL));
		send_event(mk(EV_MIDDLE_UP, 100, 80, CLR_ALL));
	endtask

	task automatic test_counter_extremes();
		send_event(mk(EV_NONE, 32767, 32767, CLR_NONE));
		// counter wrap gives a delta of one
		send_event(mk(EV_NONE, -32768, -32768, CLR_NONE));
		send_event(mk(EV_NONE, 0, 0, CLR_NONE));
		send_event(mk(EV_NONE, 0, 0, CLR_NONE));
		send_event(mk(EV_NONE, -1, 5, CLR_NONE));
	endtask

	task automatic test_ratio_cases();
		settle();
		write_reg(CFG_X_RATIO, 12'hFC8);
		write_reg(CFG_Y_RATIO, 12'h0FF);
		write_reg(CFG_SCREEN_WIDTH, 12'd4095);
		write_reg(CFG_SCREEN_HEIGHT, 12'd0);
		send_event(mk(EV_LEFT_DOWN, 149, -295, CLR_ALL));
		send_event(mk(EV_NONE, 400, -295, CLR_NONE));
		send_event(mk(EV_RIGHT_DOWN, 550, -295, CLR_NONE));
		settle();
		// remainder now above the new ratio; ratio zero acts as one
		write_reg(CFG_X_RATIO, 12'h007);
		write_reg(CFG_Y_RATIO, 12'hF00);
		write_reg(CFG_SCREEN_HEIGHT, 12'd4095);
		send_event(mk(EV_NONE, 551, -290, CLR_NONE));
		send_event(mk(EV_MIDDLE_DOWN, 540, -300, CLR_NONE));
	endtask

	task automatic test_disabled_latch_clear();
		settle();
		write_reg(CFG_ENABLE, 12'hFFE);
		send_event(mk(EV_ALL_DOWN, 1000, 1000, CLR_OUTER));
		settle();
		write_reg(CFG_ENABLE, 12'h801);
		// counters moved while off: the jump is taken from the last tracked value
		send_event(mk(EV_NONE, 1000, 1000, CLR_NONE));
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(CFG_ENABLE, {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 5) != 0)});
			write_reg(CFG_X_RATIO, pick_ratio());
			write_reg(CFG_Y_RATIO, pick_ratio());
			write_reg(CFG_SCREEN_WIDTH, pick_limit());
			write_reg(CFG_SCREEN_HEIGHT, pick_limit());
			for (int blk = 0; blk < BLOCKS; blk++) begin
				// quiet stretches now and then, and none at all in the last phase
				idling = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
				for (int n = 0; n < BLOCK_ITEMS; n++)
					send_event(random_event());
			end
		end
	endtask

	initial begin
		clear_tracking();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_events();
		test_buttons();
		test_counter_extremes();
		test_ratio_cases();
		test_disabled_latch_clear();
		test_random_traffic();
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_cursor_q.size() != 0)
			report_mismatch($sformatf("%0d cursor results never arrived",
				expected_cursor_q.size()));
		$display("sent %0d mouse events over %0d register writes, checked %0d cursor results",
			events_sent, reg_writes, cursors_checked);
		$display("covered button latching, counter wrap, ratio and clamp extremes, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
